// ----- sv/stm_pkg.sv -----
package stm_pkg;

    // Default sizes of the table
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF       = 11;

    // Fixed field widths
    localparam int WORD_W  = 32;
    localparam int Q_W     = 10;
    localparam int QLEN_W  = Q_W + 1;
    localparam int QLVL_W  = $clog2(QLEN_W);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [Q_W-1:0]           t_qidx;
    typedef logic [QLEN_W-1:0]        t_qlen;
    typedef logic [QLVL_W-1:0]        t_qlvl;

    // Item function codes
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Table write control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic wr_min;
    } t_mem_ctl;

    // Result register control from the sequencer
    typedef struct packed {
        logic load;
        logic err;
    } t_res_ctl;

    // Position of the highest set bit of a range length
    function automatic t_qlvl floor_log2(input t_qlen x);
        t_qlvl r;
        r = '0;
        for (int i = 0; i < QLEN_W; i++) begin
            if (x[i]) begin
                r = QLVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/stm_if.sv -----
interface stm_in_if import stm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_func func;
    t_word value;
    logic  last;
    t_qidx query_left;
    t_qidx query_right;

    modport source (output valid, func, value, last, query_left, query_right, input ready);
    modport sink   (input valid, func, value, last, query_left, query_right, output ready);
endinterface

interface stm_out_if import stm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word min_value;
    logic  range_error;

    modport source (output valid, min_value, range_error, input ready);
    modport sink   (input valid, min_value, range_error, output ready);
endinterface

// ----- sv/stm_table_mem.sv -----
module stm_table_mem import stm_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int LEVELS       = LEVELS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [$clog2(LEVELS)+$clog2(MAX_ELEMENTS)-1:0] i_wr_addr,
    input  t_word                                        i_wr_data,
    input  logic [$clog2(LEVELS)+$clog2(MAX_ELEMENTS)-1:0] i_rd_addr_a,
    input  logic [$clog2(LEVELS)+$clog2(MAX_ELEMENTS)-1:0] i_rd_addr_b,
    output t_word                                        o_rd_data_a,
    output t_word                                        o_rd_data_b
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int DEPTH = LEVELS * (2 ** IDX_W);

    t_word r_mem [0:DEPTH-1];
    t_word r_rd_a;
    t_word r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- sv/stm_seq.sv -----
module stm_seq import stm_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int LEVELS       = LEVELS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_accept,
    input  t_func                                        i_func,
    input  logic                                         i_last,
    input  t_qidx                                        i_left,
    input  t_qidx                                        i_right,
    input  logic                                         i_out_free,
    output logic                                         o_idle,
    output t_mem_ctl                                     o_mem_ctl,
    output logic [$clog2(LEVELS)+$clog2(MAX_ELEMENTS)-1:0] o_wr_addr,
    output logic [$clog2(LEVELS)+$clog2(MAX_ELEMENTS)-1:0] o_rd_addr_a,
    output logic [$clog2(LEVELS)+$clog2(MAX_ELEMENTS)-1:0] o_rd_addr_b,
    output t_res_ctl                                     o_res_ctl
);

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SPAN_W = CNT_W + 1;
    localparam int SUM_W  = SPAN_W + 1;
    localparam int CMP_W  = (CNT_W > Q_W) ? CNT_W : Q_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_QADDR,
        S_QCMP
    } t_state;

    // Control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_tbl_ok, n_tbl_ok;
    logic              r_wr_pend, n_wr_pend;

    // Build counters and query operands
    logic [LVL_W:0]    r_lvl, n_lvl;
    logic [SPAN_W-1:0] r_span, n_span;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_jb, n_jb;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    t_qidx             r_left, n_left;
    t_qidx             r_right, n_right;
    t_qlen             r_len, n_len;
    logic              r_qerr, n_qerr;

    logic [CNT_W-1:0]  cnt_eff;
    logic              store;
    logic              issue;
    logic [LVL_W-1:0]  q_lvl;
    t_qlvl             q_log;
    t_qlen             q_idx_b;
    logic [LVL_W-1:0]  lvl_lo;
    logic [ADDR_W-1:0] load_addr;

    always_comb begin
        // Defaults: hold, with the pending write cleared
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_tbl_ok  = r_tbl_ok;
        n_wr_pend = 1'b0;
        n_lvl     = r_lvl;
        n_span    = r_span;
        n_j       = r_j;
        n_jb      = r_jb;
        n_wr_addr = r_wr_addr;
        n_left    = r_left;
        n_right   = r_right;
        n_len     = r_len;
        n_qerr    = r_qerr;

        o_rd_addr_a = '0;
        o_rd_addr_b = '0;
        o_res_ctl   = '0;

        // Element slot of a load: a built table starts a new array
        cnt_eff   = r_tbl_ok ? '0 : r_cnt;
        store     = (cnt_eff < MAX_ELEMENTS);
        load_addr = {LVL_W'(0), cnt_eff[IDX_W-1:0]};

        // Build step test: one more entry fits in this level
        issue  = (r_lvl <= LEVELS - 1)
              && (SUM_W'(r_j) + SUM_W'(r_span) <= SUM_W'(r_cnt));
        lvl_lo = LVL_W'(r_lvl - 1'b1);

        // Query level and second window start
        q_log   = floor_log2(r_len);
        q_lvl   = (q_log >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(q_log);
        q_idx_b = QLEN_W'(QLEN_W'(r_right) + 1'b1 - (QLEN_W'(1) << q_lvl));

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_func == FUNC_LOAD) begin
                        n_tbl_ok = 1'b0;
                        n_cnt    = store ? CNT_W'(cnt_eff + 1'b1) : cnt_eff;
                        if (i_last) begin
                            n_state = S_BUILD;
                            n_lvl   = (LVL_W + 1)'(1);
                            n_span  = SPAN_W'(2);
                            n_j     = '0;
                            n_jb    = CNT_W'(1);
                        end
                    end else begin
                        n_left  = i_left;
                        n_right = i_right;
                        n_len   = QLEN_W'(QLEN_W'(i_right) - QLEN_W'(i_left) + 1'b1);
                        n_qerr  = !r_tbl_ok || (i_left > i_right)
                               || (CMP_W'(i_right) >= CMP_W'(r_cnt));
                        n_state = S_QADDR;
                    end
                end
            end
            S_BUILD: begin
                if (issue) begin
                    // Read both halves, write the minimum next cycle
                    o_rd_addr_a = {lvl_lo, r_j[IDX_W-1:0]};
                    o_rd_addr_b = {lvl_lo, r_jb[IDX_W-1:0]};
                    n_wr_pend   = 1'b1;
                    n_wr_addr   = {r_lvl[LVL_W-1:0], r_j[IDX_W-1:0]};
                    n_j         = CNT_W'(r_j + 1'b1);
                    n_jb        = CNT_W'(r_jb + 1'b1);
                end else if (r_j == '0) begin
                    // Level has no entry: build complete
                    n_tbl_ok = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    // Advance level; this cycle drains the last write
                    n_lvl  = (LVL_W + 1)'(r_lvl + 1'b1);
                    n_span = SPAN_W'(r_span << 1);
                    n_j    = '0;
                    n_jb   = CNT_W'(r_span);
                end
            end
            S_QADDR: begin
                o_rd_addr_a = {q_lvl, IDX_W'(r_left)};
                o_rd_addr_b = {q_lvl, IDX_W'(q_idx_b)};
                n_state     = S_QCMP;
            end
            S_QCMP: begin
                // Keep the read addresses so the read data holds while stalled
                o_rd_addr_a = {q_lvl, IDX_W'(r_left)};
                o_rd_addr_b = {q_lvl, IDX_W'(q_idx_b)};
                // Hold until the result register is free
                if (i_out_free) begin
                    o_res_ctl.load = 1'b1;
                    o_res_ctl.err  = r_qerr;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table write port: pending build write or an accepted load
    always_comb begin
        o_mem_ctl = '0;
        o_wr_addr = load_addr;
        if (r_wr_pend) begin
            o_mem_ctl.wr_en  = 1'b1;
            o_mem_ctl.wr_min = 1'b1;
            o_wr_addr        = r_wr_addr;
        end else if (r_state == S_IDLE && i_accept && i_func == FUNC_LOAD && store) begin
            o_mem_ctl.wr_en = 1'b1;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_tbl_ok  <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_tbl_ok  <= n_tbl_ok;
            r_wr_pend <= n_wr_pend;
        end
    end

    // Counters and operands
    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_span    <= n_span;
        r_j       <= n_j;
        r_jb      <= n_jb;
        r_wr_addr <= n_wr_addr;
        r_left    <= n_left;
        r_right   <= n_right;
        r_len     <= n_len;
        r_qerr    <= n_qerr;
    end

endmodule

// ----- sv/sparse_table_range_min_core.sv -----
// Load: one element per cycle while idle. The last load starts the table build,
// which writes one entry per cycle within a level through the single table write
// port. Query: no new transaction is taken until the query is done; the table is
// read in S_QADDR and the result register is loaded in S_QCMP, which waits while
// the register stays full. Reset clears the sequencer, element count and ready
// flag; table contents stay undefined, and unwritten entries never reach a result.
module sparse_table_range_min_core import stm_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int LEVELS       = LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stm_in_if.sink    i_in,
    stm_out_if.source o_out
);

    localparam int ADDR_W = $clog2(LEVELS) + $clog2(MAX_ELEMENTS);

    t_mem_ctl          mem_ctl;
    t_res_ctl          res_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    t_word             rd_a;
    t_word             rd_b;
    t_word             min_word;
    t_word             wr_data;
    logic              idle;
    logic              accept;
    logic              out_free;

    logic              r_out_valid;
    t_word             r_min;
    logic              r_err;

    assign i_in.ready = idle;
    assign accept     = i_in.valid && idle;
    assign out_free   = !r_out_valid || o_out.ready;

    stm_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_in.func),
        .i_last      (i_in.last),
        .i_left      (i_in.query_left),
        .i_right     (i_in.query_right),
        .i_out_free  (out_free),
        .o_idle      (idle),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_res_ctl   (res_ctl)
    );

    stm_table_mem #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (mem_ctl.wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    // Shared signed minimum, used by build and query
    assign min_word = (rd_b < rd_a) ? rd_b : rd_a;
    assign wr_data  = mem_ctl.wr_min ? min_word : i_in.value;

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; an erroneous range answers zero
    always_ff @(posedge i_clk) begin
        if (res_ctl.load) begin
            r_min <= res_ctl.err ? '0 : min_word;
            r_err <= res_ctl.err;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.min_value   = r_min;
    assign o_out.range_error = r_err;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import stm_pkg::*;

    localparam int MAX_ELEMS    = MAX_ELEMENTS_DEF;
    localparam int LEVEL_CNT    = LEVELS_DEF;
    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_ITEMS   = 120;
    localparam int STALL_LIMIT  = 50000;
    localparam int REPORT_MAX   = 10;

    // One pending input transaction
    typedef struct {
        t_func func;
        t_word value;
        logic  last;
        t_qidx q_left;
        t_qidx q_right;
        bit    wait_drain;
    } t_stim_item;

    typedef struct packed {
        t_word min_value;
        logic  range_error;
    } t_range_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stm_in_if  in_if ();
    stm_out_if out_if ();

    sparse_table_range_min_core #(
        .MAX_ELEMENTS (MAX_ELEMS),
        .LEVELS       (LEVEL_CNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    // Predicted table contents and state
    t_word min_levels [LEVEL_CNT][MAX_ELEMS];
    int    tbl_len = 0;
    bit    tbl_ready = 1'b0;

    t_stim_item    stim_q [$];
    t_range_answer answers_due [$];
    t_stim_item    cur_item;

    // Generator view of the array length
    int gen_len = 0;
    bit gen_built = 1'b0;
    int n_gen = 0;

    // Handshake bookkeeping
    int queries_sent = 0;
    int results_taken = 0;
    int n_faults = 0;
    bit in_fire;
    bit tail_quiet = 1'b0;
    int send_gap = 0;
    int take_gap = 0;
    int send_pct = 0;
    int take_pct = 0;
    int hold_left = 0;
    int holds_done = 0;
    int cyc = 0;
    int stale = 0;

    // Run statistics
    int n_loads = 0;
    int n_dropped = 0;
    int n_builds = 0;
    int n_in_range = 0;
    int n_rejected = 0;
    int longest = 0;

    // Fill levels 1 up to floor(log2 n) from level 0
    task automatic build_levels();
        int top;
        int half;
        t_word a;
        t_word b;
        if (tbl_len == 0) return;
        top = $clog2(tbl_len + 1) - 1;
        if (top > LEVEL_CNT - 1) top = LEVEL_CNT - 1;
        for (int k = 1; k <= top; k++) begin
            half = 1 << (k - 1);
            for (int j = 0; j + (1 << k) <= tbl_len; j++) begin
                a = min_levels[k-1][j];
                b = min_levels[k-1][j+half];
                min_levels[k][j] = (b < a) ? b : a;
            end
        end
        if (tbl_len > longest) longest = tbl_len;
    endtask

    // Advance the predicted state by one accepted transaction
    task automatic apply_item(input t_stim_item it);
        t_range_answer ans;
        int lvl;
        int lo_idx;
        int hi_idx;
        t_word a;
        t_word b;
        if (it.func == FUNC_LOAD) begin
            n_loads++;
            if (tbl_ready) begin
                tbl_len = 0;
                tbl_ready = 1'b0;
            end
            if (tbl_len < MAX_ELEMS) begin
                min_levels[0][tbl_len] = it.value;
                tbl_len++;
            end else begin
                n_dropped++;
            end
            if (it.last) begin
                build_levels();
                tbl_ready = 1'b1;
                n_builds++;
            end
        end else begin
            queries_sent++;
            lo_idx = int'(it.q_left);
            hi_idx = int'(it.q_right);
            if (!tbl_ready || lo_idx > hi_idx || hi_idx >= tbl_len) begin
                ans = '{min_value: '0, range_error: 1'b1};
                n_rejected++;
            end else begin
                lvl = $clog2(hi_idx - lo_idx + 2) - 1;
                if (lvl > LEVEL_CNT - 1) lvl = LEVEL_CNT - 1;
                a = min_levels[lvl][lo_idx];
                b = min_levels[lvl][hi_idx + 1 - (1 << lvl)];
                ans = '{min_value: (b < a) ? b : a, range_error: 1'b0};
                n_in_range++;
            end
            answers_due.push_back(ans);
        end
    endtask

    function automatic t_word pick_value(input int style);
        case (style)
            0: return t_word'($urandom);
            1: return t_word'(int'($urandom_range(40)) - 20);
            2: begin
                case ($urandom_range(3))
                    0: return t_word'(32'h8000_0000);
                    1: return t_word'(32'h7fff_ffff);
                    2: return t_word'(-1);
                    default: return t_word'(0);
                endcase
            end
            default: return pick_value($urandom_range(2));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 12;
            default: return 45;
        endcase
    endfunction

    task automatic add_load(input t_word v, input bit fin, input bit drain);
        t_stim_item it;
        it.func = FUNC_LOAD;
        it.value = v;
        it.last = fin;
        it.q_left = t_qidx'($urandom);
        it.q_right = t_qidx'($urandom);
        it.wait_drain = drain;
        stim_q.push_back(it);
        if (gen_built) begin
            gen_len = 0;
            gen_built = 1'b0;
        end
        if (gen_len < MAX_ELEMS) gen_len++;
        if (fin) gen_built = 1'b1;
        n_gen++;
    endtask

    // Query with junk in the load-only fields
    task automatic add_query(input int lo, input int hi, input bit drain);
        t_stim_item it;
        it.func = FUNC_QUERY;
        it.value = t_word'($urandom);
        it.last = $urandom_range(1);
        it.q_left = t_qidx'(lo);
        it.q_right = t_qidx'(hi);
        it.wait_drain = drain;
        stim_q.push_back(it);
        n_gen++;
    endtask

    task automatic add_good_query();
        int lo;
        int hi;
        if (gen_len == 0) begin
            add_query($urandom_range(1023), $urandom_range(1023), 1'b0);
            return;
        end
        lo = $urandom_range(gen_len - 1);
        hi = $urandom_range(gen_len - 1, lo);
        // stretch some ranges to the end for the upper levels
        if ($urandom_range(3) == 0) begin
            lo = lo / 8;
            hi = gen_len - 1;
        end
        add_query(lo, hi, 1'b0);
    endtask

    task automatic add_bad_query();
        int lo;
        int hi;
        case ($urandom_range(2))
            0: begin
                hi = $urandom_range(1022);
                lo = $urandom_range(1023, hi + 1);
            end
            1: begin
                if (gen_len < MAX_ELEMS) begin
                    hi = $urandom_range(1023, gen_len);
                    lo = $urandom_range(hi);
                end else begin
                    hi = $urandom_range(1022);
                    lo = $urandom_range(1023, hi + 1);
                end
            end
            default: begin
                lo = $urandom_range(1023);
                hi = $urandom_range(1023);
            end
        endcase
        add_query(lo, hi, 1'b0);
    endtask

    // Loads, with stray queries mixed in, then a burst of queries
    task automatic add_session(input int n, input int nq, input bit fin, input bit drain);
        int style;
        style = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(99) < 6) add_bad_query();
            add_load(pick_value(style), fin && (i == n - 1), drain && (i == 0));
        end
        for (int i = 0; i < nq; i++) begin
            if ($urandom_range(99) < 80) add_good_query();
            else add_bad_query();
        end
    endtask

    // Input driver: hold an offered transaction until taken, else idle or offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            in_fire = in_if.valid && in_if.ready;
            if (in_fire) apply_item(cur_item);
            tail_quiet <= (stim_q.size() < TAIL_ITEMS);
            if (in_if.valid && !in_fire) begin
                // hold
            end else if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (stim_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (stim_q[0].wait_drain && queries_sent != results_taken) begin
                in_if.valid <= 1'b0;
            end else if (!tail_quiet && $urandom_range(99) < send_pct) begin
                send_gap = $urandom_range(17, 1) - 1;
                in_if.valid <= 1'b0;
            end else begin
                cur_item = stim_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.func        <= cur_item.func;
                in_if.value       <= cur_item.value;
                in_if.last        <= cur_item.last;
                in_if.query_left  <= cur_item.q_left;
                in_if.query_right <= cur_item.q_right;
            end
        end
    end

    // Result monitor: check each transaction, then choose ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            take_gap = 0;
            hold_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_taken <= results_taken + 1;
                if (answers_due.size() == 0) begin
                    if (n_faults < REPORT_MAX)
                        $display("%0t: result with no query outstanding: min_value %0d range_error %0b",
                                 $time, out_if.min_value, out_if.range_error);
                    n_faults++;
                end else if (out_if.min_value !== answers_due[0].min_value ||
                             out_if.range_error !== answers_due[0].range_error) begin
                    if (n_faults < REPORT_MAX)
                        $display("%0t: mismatch: min_value exp %0d got %0d, range_error exp %0b got %0b",
                                 $time, answers_due[0].min_value, out_if.min_value,
                                 answers_due[0].range_error, out_if.range_error);
                    n_faults++;
                    void'(answers_due.pop_front());
                end else begin
                    void'(answers_due.pop_front());
                end
            end
            // long hold-offs to back the block up into its input
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!tail_quiet &&
                         ((holds_done == 0 && results_taken >= 60) ||
                          (holds_done == 1 && results_taken >= 300))) begin
                holds_done++;
                hold_left = 399;
                out_if.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                out_if.ready <= 1'b0;
            end else if (!tail_quiet && $urandom_range(99) < take_pct) begin
                take_gap = $urandom_range(17, 1) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Reroll the idling density so some stretches run flat out
    always @(posedge i_clk) begin
        if (cyc % 128 == 0) begin
            send_pct <= pick_pct();
            take_pct <= pick_pct();
        end
        cyc <= cyc + 1;
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stale <= 0;
        end else begin
            stale <= stale + 1;
            if (stale >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.func = FUNC_LOAD;
        in_if.value = '0;
        in_if.last = 1'b0;
        in_if.query_left = '0;
        in_if.query_right = '0;
        out_if.ready = 1'b0;

        // Directed: query before any build
        add_query(0, 0, 1'b0);
        // Extremes of the value field, build over five elements
        add_load(t_word'(32'h8000_0000), 1'b0, 1'b0);
        add_load(t_word'(32'h7fff_ffff), 1'b0, 1'b0);
        add_load(t_word'(-1), 1'b0, 1'b0);
        add_load(t_word'(0), 1'b0, 1'b0);
        add_load(t_word'(1), 1'b1, 1'b0);
        add_query(0, 4, 1'b0);
        add_query(1, 4, 1'b0);
        add_query(1, 1, 1'b0);
        add_query(3, 4, 1'b0);
        // Bad ranges: reversed, past the end, extremes of the index fields
        add_query(3, 2, 1'b0);
        add_query(0, 5, 1'b0);
        add_query(1023, 1023, 1'b0);
        add_query(0, 1023, 1'b0);
        // Load after build starts a new array; no table until its last load
        add_load(t_word'(7), 1'b0, 1'b1);
        add_query(0, 0, 1'b0);
        add_load(t_word'(8), 1'b1, 1'b0);
        add_query(0, 1, 1'b0);
        add_query(1, 1, 1'b0);
        // Single-element array
        add_load(t_word'(-5), 1'b1, 1'b0);
        add_query(0, 0, 1'b0);
        add_query(0, 1, 1'b0);

        // Full array, with two loads past capacity; the last mark rides on a dropped one
        for (int i = 0; i < MAX_ELEMS + 2; i++) begin
            add_load((i < MAX_ELEMS) ? pick_value(($urandom_range(15) == 0) ? 0 : 1)
                                     : t_word'(32'h8000_0000),
                     i == MAX_ELEMS + 1, i == 0);
        end
        add_query(0, 1023, 1'b0);
        add_query(1023, 1023, 1'b0);
        add_query(0, 0, 1'b0);
        add_query(512, 1023, 1'b0);
        add_query(1, 1022, 1'b0);
        add_query(1023, 0, 1'b0);
        for (int i = 0; i < 24; i++) add_good_query();

        // Random sessions, mostly small arrays
        n_gen = 0;
        while (n_gen < RANDOM_ITEMS) begin
            int pick;
            int n;
            bit fin;
            pick = $urandom_range(99);
            if (pick < 80) n = $urandom_range(24, 1);
            else if (pick < 95) n = $urandom_range(100, 25);
            else n = $urandom_range(300, 101);
            fin = ($urandom_range(99) >= 8);
            add_session(n, fin ? $urandom_range(24, 4) : $urandom_range(3, 1), fin,
                        $urandom_range(3) == 0);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then let the pipeline settle
        while (stim_q.size() != 0 || in_if.valid || queries_sent != results_taken)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (answers_due.size() != 0) begin
            $display("%0d expected answers never arrived", answers_due.size());
            n_faults += answers_due.size();
        end
        $display("covered %0d loads (%0d past capacity), %0d table builds, largest array %0d",
                 n_loads, n_dropped, n_builds, longest);
        $display("%0d queries: %0d in range, %0d rejected; %0d check failures",
                 queries_sent, n_in_range, n_rejected, n_faults);
        if (n_faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
